// ----- design/baro_second_order_compensation_assert.svh -----
// Assertion helpers shared by the compensation block.
`ifndef BARO_SECOND_ORDER_COMPENSATION_ASSERT_SVH
`define BARO_SECOND_ORDER_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsoc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BSOC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsoc: next-cycle check failed");

`endif

// ----- design/bsoc_pkg.sv -----
`default_nettype none
package bsoc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int PRES_W  = 17;
    localparam int TEMP_W  = 20;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Internal datapath widths
    localparam int DT_W    = 25;
    localparam int OFF1_W  = 37;
    localparam int SENS1_W = 36;
    localparam int T2_W    = 18;
    localparam int OFF_W   = 40;
    localparam int SENS_W  = 40;

    // Temperature thresholds in hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = -20'sd1500;

    // Accepted pressure window and temperature output bounds
    localparam int P_MIN_PA     = 30000;
    localparam int P_MAX_PA     = 120000;
    localparam int TEMP_OUT_MIN = -260200;
    localparam int TEMP_OUT_MAX = 133100;

    // Calibration register indexes
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // First-order results
    typedef struct packed {
        logic        [RAW_W-1:0]   d1;
        logic signed [TEMP_W-1:0]  temp1;
        logic signed [OFF1_W-1:0]  off1;
        logic signed [SENS1_W-1:0] sens1;
        logic        [T2_W-1:0]    t2;
    } t_fo;

    // Fully corrected terms
    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_so;

endpackage
`default_nettype wire

// ----- design/bsoc_ifs.sv -----
`default_nettype none
interface bsoc_in_if
    import bsoc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source(output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bsoc_out_if
    import bsoc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [PRES_W-1:0]        pressure_pa;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic                     status;

    modport source(output valid, output pressure_pa, output temperature_centi,
                   output status, input ready);
    modport sink(input valid, input pressure_pa, input temperature_centi,
                 input status, output ready);
endinterface
`default_nettype wire

// ----- design/bsoc_cfg.sv -----
`default_nettype none
module bsoc_cfg import bsoc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cal                   o_cal
);

    t_cal     r_cal;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cal  = r_cal;

    // Write calibration words; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_C1:  r_cal.c1 <= pwdata[CAL_W-1:0];
                REG_C2:  r_cal.c2 <= pwdata[CAL_W-1:0];
                REG_C3:  r_cal.c3 <= pwdata[CAL_W-1:0];
                REG_C4:  r_cal.c4 <= pwdata[CAL_W-1:0];
                REG_C5:  r_cal.c5 <= pwdata[CAL_W-1:0];
                REG_C6:  r_cal.c6 <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_C1:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c1};
            REG_C2:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c2};
            REG_C3:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c3};
            REG_C4:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c4};
            REG_C5:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c5};
            REG_C6:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.c6};
            default: prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/bsoc_first_order.sv -----
`default_nettype none
module bsoc_first_order import bsoc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cal i_cal,
    bsoc_in_if.sink   i_in,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_fo       o_fo
);

    logic [2:0] r_vld;
    logic [3:0] w_rdy;

    // Stage 1: temperature difference
    logic        [RAW_W-1:0] r_s1_d1;
    logic signed [DT_W-1:0]  r_s1_dt;
    logic signed [DT_W-1:0]  n_s1_dt;

    // Stage 2: products of dT
    logic        [RAW_W-1:0] r_s2_d1;
    logic signed [41:0]      r_s2_mt, n_s2_mt;
    logic signed [41:0]      r_s2_mo, n_s2_mo;
    logic signed [41:0]      r_s2_ms, n_s2_ms;
    logic signed [49:0]      r_s2_mq, n_s2_mq;

    // Stage 3: first-order terms
    t_fo r_s3, n_s3;

    // Per-stage ready; a bubble lets upstream advance past a stall
    assign w_rdy[3] = i_ready;
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign i_in.ready = w_rdy[0];
    assign o_valid    = r_vld[2];
    assign o_fo       = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_in.valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // dT = D2 - C5 * 256
    assign n_s1_dt = $signed({1'b0, i_in.raw_temperature})
                   - $signed({1'b0, i_cal.c5, 8'h00});

    // Multiply dT by its coefficients and by itself
    assign n_s2_mt = r_s1_dt * $signed({1'b0, i_cal.c6});
    assign n_s2_mo = r_s1_dt * $signed({1'b0, i_cal.c4});
    assign n_s2_ms = r_s1_dt * $signed({1'b0, i_cal.c3});
    assign n_s2_mq = r_s1_dt * r_s1_dt;

    // Scale and offset into TEMP, OFF, SENS and T2
    always_comb begin
        n_s3.d1    = r_s2_d1;
        n_s3.temp1 = $signed(TEMP_W'(r_s2_mt >>> 23)) + TEMP_REF;
        n_s3.off1  = $signed({5'h00, i_cal.c2, 16'h0000})
                   + $signed(OFF1_W'(r_s2_mo >>> 7));
        n_s3.sens1 = $signed({5'h00, i_cal.c1, 15'h0000})
                   + $signed(SENS1_W'(r_s2_ms >>> 8));
        n_s3.t2    = T2_W'(r_s2_mq >>> 31);
    end

    // Advance payload where the stage loads
    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_in.valid) begin
            r_s1_d1 <= i_in.raw_pressure;
            r_s1_dt <= n_s1_dt;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s2_d1 <= r_s1_d1;
            r_s2_mt <= n_s2_mt;
            r_s2_mo <= n_s2_mo;
            r_s2_ms <= n_s2_ms;
            r_s2_mq <= n_s2_mq;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_s3 <= n_s3;
        end
    end

endmodule
`default_nettype wire

// ----- design/bsoc_second_order.sv -----
`default_nettype none
module bsoc_second_order import bsoc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_fo  i_fo,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_so       o_so
);

    logic [1:0] r_vld;
    logic [2:0] w_rdy;

    // Stage 4: squares and threshold flags
    logic        [RAW_W-1:0]   r_s4_d1;
    logic signed [TEMP_W-1:0]  r_s4_temp1;
    logic signed [OFF1_W-1:0]  r_s4_off1;
    logic signed [SENS1_W-1:0] r_s4_sens1;
    logic        [T2_W-1:0]    r_s4_t2;
    logic signed [41:0]        r_s4_aa, n_s4_aa;
    logic signed [41:0]        r_s4_bb, n_s4_bb;
    logic                      r_s4_lt20, n_s4_lt20;
    logic                      r_s4_ltm15, n_s4_ltm15;
    logic signed [TEMP_W:0]    w_a;
    logic signed [TEMP_W:0]    w_b;

    // Stage 5: corrected terms
    t_so r_s5, n_s5;
    logic signed [44:0] w_aa5;
    logic signed [44:0] w_bb7;
    logic signed [45:0] w_bb11;
    logic signed [46:0] w_off2;
    logic signed [46:0] w_sens2;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[1];
    assign o_so    = r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Distances from the two thresholds, squared
    assign w_a        = i_fo.temp1 - TEMP_REF;
    assign w_b        = i_fo.temp1 - TEMP_LOW;
    assign n_s4_aa    = w_a * w_a;
    assign n_s4_bb    = w_b * w_b;
    assign n_s4_lt20  = i_fo.temp1 < TEMP_REF;
    assign n_s4_ltm15 = i_fo.temp1 < TEMP_LOW;

    // Constant multiples by shift and add
    assign w_aa5  = (45'(r_s4_aa) <<< 2) + 45'(r_s4_aa);
    assign w_bb7  = (45'(r_s4_bb) <<< 3) - 45'(r_s4_bb);
    assign w_bb11 = (46'(r_s4_bb) <<< 3) + (46'(r_s4_bb) <<< 1) + 46'(r_s4_bb);

    // Gather OFF2 and SENS2 below each threshold
    always_comb begin
        w_off2  = '0;
        w_sens2 = '0;
        if (r_s4_lt20) begin
            w_off2  = 47'(w_aa5 >>> 1);
            w_sens2 = 47'(w_aa5 >>> 2);
            if (r_s4_ltm15) begin
                w_off2  = w_off2 + 47'(w_bb7);
                w_sens2 = w_sens2 + 47'(w_bb11 >>> 1);
            end
        end
    end

    always_comb begin
        n_s5.d1   = r_s4_d1;
        n_s5.temp = r_s4_lt20 ? r_s4_temp1 - $signed({2'b00, r_s4_t2}) : r_s4_temp1;
        n_s5.off  = OFF_W'(47'(r_s4_off1) - w_off2);
        n_s5.sens = SENS_W'(47'(r_s4_sens1) - w_sens2);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s4_d1    <= i_fo.d1;
            r_s4_temp1 <= i_fo.temp1;
            r_s4_off1  <= i_fo.off1;
            r_s4_sens1 <= i_fo.sens1;
            r_s4_t2    <= i_fo.t2;
            r_s4_aa    <= n_s4_aa;
            r_s4_bb    <= n_s4_bb;
            r_s4_lt20  <= n_s4_lt20;
            r_s4_ltm15 <= n_s4_ltm15;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s5 <= n_s5;
        end
    end

endmodule
`default_nettype wire

// ----- design/bsoc_pressure.sv -----
`default_nettype none
module bsoc_pressure import bsoc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_so   i_so,
    bsoc_out_if.source o_out
);

    logic [1:0] r_vld;
    logic [2:0] w_rdy;

    // Stage 6: D1 * SENS as two partial products
    logic        [43:0]       r_s6_plo, n_s6_plo;
    logic signed [44:0]       r_s6_phi, n_s6_phi;
    logic signed [OFF_W-1:0]  r_s6_off;
    logic signed [TEMP_W-1:0] r_s6_temp;

    // Stage 7: pressure, range check, output register
    logic        [PRES_W-1:0] r_s7_pa, n_s7_pa;
    logic signed [TEMP_W-1:0] r_s7_temp;
    logic                     r_s7_bad, n_s7_bad;
    logic signed [65:0]       w_full;
    logic signed [44:0]       w_x;
    logic signed [45:0]       w_y;
    logic signed [30:0]       w_p;

    assign w_rdy[2] = o_out.ready;
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign o_ready                 = w_rdy[0];
    assign o_out.valid             = r_vld[1];
    assign o_out.pressure_pa       = r_s7_pa;
    assign o_out.temperature_centi = r_s7_temp;
    assign o_out.status            = r_s7_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_valid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Split SENS into a signed upper half and an unsigned lower half
    assign n_s6_plo = i_so.d1 * i_so.sens[19:0];
    assign n_s6_phi = $signed({1'b0, i_so.d1}) * $signed(i_so.sens[SENS_W-1:20]);

    // P = ((D1 * SENS >> 21) - OFF) >> 15
    assign w_full = $signed({r_s6_phi, 20'h00000}) + $signed({22'd0, r_s6_plo});
    assign w_x    = 45'(w_full >>> 21);
    assign w_y    = 46'(w_x) - 46'(r_s6_off);
    assign w_p    = 31'(w_y >>> 15);

    // Reject pressure outside the window and zero the field
    assign n_s7_bad = (w_p < $signed(31'(P_MIN_PA))) || (w_p > $signed(31'(P_MAX_PA)));
    assign n_s7_pa  = n_s7_bad ? '0 : w_p[PRES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_s6_plo  <= n_s6_plo;
            r_s6_phi  <= n_s6_phi;
            r_s6_off  <= i_so.off;
            r_s6_temp <= i_so.temp;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_s7_pa   <= n_s7_pa;
            r_s7_temp <= r_s6_temp;
            r_s7_bad  <= n_s7_bad;
        end
    end

endmodule
`default_nettype wire

// ----- design/baro_second_order_compensation.sv -----
// Barometric second-order compensation. Each transfer on i_in carries one raw
// pressure word (D1) and one raw temperature word (D2); each produces exactly one
// transfer on o_out with pressure in pascals, temperature in hundredths of a degree
// and a status bit that is set, with the pressure field zero, when the pressure
// falls outside 30000..120000 Pa. The datapath is a seven-stage pipeline: it takes
// one reading pair every cycle while o_out is not stalled. Every stage holds its
// own valid bit, so a stall on o_out fills empty stages before back-pressure
// reaches i_in. The six 16-bit calibration words C1..C6 sit at APB byte addresses
// 0x00..0x14, read back on prdata and reset to zero; write them only while no
// reading is in flight.
`default_nettype none
`include "baro_second_order_compensation_assert.svh"
module baro_second_order_compensation import bsoc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    bsoc_in_if.sink                i_in,
    bsoc_out_if.source             o_out
);

    t_cal w_cal;
    t_fo  w_fo;
    t_so  w_so;
    logic w_fo_vld, w_fo_rdy;
    logic w_so_vld, w_so_rdy;
    logic w_pa_in_window;
    logic w_temp_in_range;
    logic w_c5_write;

    bsoc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (w_cal)
    );

    bsoc_first_order u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (w_cal),
        .i_in    (i_in),
        .o_valid (w_fo_vld),
        .i_ready (w_fo_rdy),
        .o_fo    (w_fo)
    );

    bsoc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fo_vld),
        .o_ready (w_fo_rdy),
        .i_fo    (w_fo),
        .o_valid (w_so_vld),
        .i_ready (w_so_rdy),
        .o_so    (w_so)
    );

    bsoc_pressure u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_so_vld),
        .o_ready (w_so_rdy),
        .i_so    (w_so),
        .o_out   (o_out)
    );

    // Conditions watched by the checks below
    assign w_pa_in_window  = (o_out.pressure_pa >= PRES_W'(P_MIN_PA))
                          && (o_out.pressure_pa <= PRES_W'(P_MAX_PA));
    assign w_temp_in_range = (o_out.temperature_centi >= $signed(TEMP_W'(TEMP_OUT_MIN)))
                          && (o_out.temperature_centi <= $signed(TEMP_W'(TEMP_OUT_MAX)));
    assign w_c5_write      = psel && penable && pwrite
                          && (t_reg_idx'(paddr[ADDR_W-1:2]) == REG_C5);

    // A rejected pressure reads as zero
    `BSOC_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, o_out.valid && o_out.status, o_out.pressure_pa == '0)

    // An accepted pressure lies in the window
    `BSOC_ASSERT_IMP(a_accept_window, i_clk, i_rst_n, o_out.valid && !o_out.status, w_pa_in_window)

    // Compensated temperature stays within its bounds
    `BSOC_ASSERT_IMP(a_temp_bounds, i_clk, i_rst_n, o_out.valid, w_temp_in_range)

    // A write to C5 lands in the calibration set
    `BSOC_ASSERT_NXT(a_cfg_c5, i_clk, i_rst_n, w_c5_write, w_cal.c5 == $past(pwdata[CAL_W-1:0]))

endmodule
`default_nettype wire
